### hdl/zhwr_pkg.sv
// zhwr_pkg: shared types, constants and helpers for the zone hysteresis
// weighted rotation unit. Depends on nothing; every other file uses it.
package zhwr_pkg;

    // Metric lanes and rotation slots
    localparam int NUM_METRICS   = 5;   // metrics allowed into the rotation (up to METRIC_INPUTS)
    localparam int METRIC_INPUTS = 5;   // metrics carried by each tick
    localparam int SLOT_W        = $clog2(METRIC_INPUTS);
    localparam int SORT_STEPS    = METRIC_INPUTS * (METRIC_INPUTS - 1) / 2;
    localparam int STEP_W        = $clog2(SORT_STEPS);

    // Arithmetic widths
    localparam int VAL_W   = 8;
    localparam int WGT_W   = 6;
    localparam int PROD_W  = VAL_W + WGT_W;
    localparam int REL_W   = 8;

    // Divide by 50: x * 5243 >> 18 is exact for x below 2**14
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 18;
    localparam logic [RECIP_W-1:0] RECIP_50 = RECIP_W'(5243);
    localparam int SCALE_W     = PROD_W + RECIP_W;

    localparam logic [VAL_W-1:0] NEUTRAL    = VAL_W'(50);
    localparam logic [VAL_W-1:0] ZONE_BND_0 = VAL_W'(25);
    localparam logic [VAL_W-1:0] ZONE_BND_1 = VAL_W'(50);
    localparam logic [VAL_W-1:0] ZONE_BND_2 = VAL_W'(75);

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_DWELL_LEN     = 2'd0;
    localparam logic [1:0] CFG_REL_FLOOR     = 2'd1;
    localparam logic [1:0] CFG_CONFIRM_COUNT = 2'd2;
    localparam logic [7:0] RST_DWELL_LEN     = 8'd30;
    localparam logic [7:0] RST_REL_FLOOR     = 8'd10;
    localparam logic [2:0] RST_CONFIRM_COUNT = 3'd3;
    localparam logic [7:0] DWELL_MAX         = 8'd255;

    // Input function codes
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef logic [1:0]        t_zone;
    typedef logic [2:0]        t_face;
    typedef logic [REL_W-1:0]  t_rel;

    // Weight per zone (row) and metric (column)
    localparam logic [WGT_W-1:0] WEIGHTS [4][METRIC_INPUTS] = '{
        '{6'd30, 6'd25, 6'd5,  6'd10, 6'd30},
        '{6'd20, 6'd20, 6'd30, 6'd10, 6'd20},
        '{6'd15, 6'd20, 6'd5,  6'd40, 6'd20},
        '{6'd10, 6'd35, 6'd0,  6'd10, 6'd45}
    };

    // Exchange sort compare order: (i, j) for i < j, i outer
    localparam int SORT_I [SORT_STEPS] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    localparam int SORT_J [SORT_STEPS] = '{1, 2, 3, 4, 2, 3, 4, 3, 4, 4};

    typedef struct packed {
        logic             func;
        logic [VAL_W-1:0] score;
        logic [VAL_W-1:0] sleep_metric;
        logic [VAL_W-1:0] emotion_metric;
        logic [VAL_W-1:0] work_metric;
        logic [VAL_W-1:0] energy_metric;
        logic [VAL_W-1:0] comfort_metric;
    } t_in;

    typedef struct packed {
        t_face face_now;
        t_zone zone_now;
        t_face faces_in_rotation;
    } t_out;

    // Compacted list handed from the merge stage to the sorter
    typedef struct packed {
        logic [METRIC_INPUTS-1:0][2:0]       faces;
        logic [METRIC_INPUTS-1:0][REL_W-1:0] rels;
        t_face                               count;
    } t_merge;

    function automatic t_zone zone_of(input logic [VAL_W-1:0] score);
        t_zone z;
        if (score <= ZONE_BND_0)      z = 2'd0;
        else if (score <= ZONE_BND_1) z = 2'd1;
        else if (score <= ZONE_BND_2) z = 2'd2;
        else                          z = 2'd3;
        return z;
    endfunction

endpackage

### hdl/zone_hysteresis_weighted_rotation_unit.sv
// Zone hysteresis weighted rotation unit: top level with the control sequencer,
// the metric lanes, the merge stage and the exchange sorter.
// Uses zhwr_pkg, zhwr_lane and zhwr_merge.
// Sequence: evaluate, then the result; when a zone change rebuilds the rotation:
//   evaluate, 2 lane stages, merge, 10 sort steps, then the result.
// Flow: a new item is taken only once the last one is through; the sorter does
//   one compare-exchange per cycle during a rebuild.
// Reset: synchronous, active low; control and config registers to defaults only.
module zone_hysteresis_weighted_rotation_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  zhwr_pkg::t_in      i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output zhwr_pkg::t_out     o_out_data,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_LANE1,
        S_LANE2,
        S_MERGE,
        S_SORT,
        S_OUT
    } t_state;

    t_state                     r_state;

    // configuration
    logic [7:0]                 r_dwell_len;
    zhwr_pkg::t_rel             r_min_rel;
    logic [2:0]                 r_confirm;

    // hysteresis and rotation state
    zhwr_pkg::t_zone            r_zone;
    zhwr_pkg::t_zone            r_pend;
    logic [2:0]                 r_cc;
    logic [7:0]                 r_dwell;
    zhwr_pkg::t_face            r_len;
    zhwr_pkg::t_face            r_pos;
    logic [zhwr_pkg::STEP_W-1:0] r_step;

    // held item and rotation list (list has no reset: read only below r_len)
    zhwr_pkg::t_in              r_item;
    logic [zhwr_pkg::METRIC_INPUTS-1:0][2:0]                r_face;
    logic [zhwr_pkg::METRIC_INPUTS-1:0][zhwr_pkg::REL_W-1:0] r_srel;

    logic                       r_out_valid;
    zhwr_pkg::t_out             r_out_data;

    // next values of the evaluate step
    zhwr_pkg::t_zone            n_zone;
    zhwr_pkg::t_zone            n_pend;
    logic [2:0]                 n_cc;
    logic [7:0]                 n_dwell;
    zhwr_pkg::t_face            n_pos;
    logic                       n_rebuild;

    // next values of one sort step
    logic [zhwr_pkg::METRIC_INPUTS-1:0][2:0]                n_face;
    logic [zhwr_pkg::METRIC_INPUTS-1:0][zhwr_pkg::REL_W-1:0] n_srel;

    zhwr_pkg::t_out             n_out;

    logic [zhwr_pkg::METRIC_INPUTS-1:0][zhwr_pkg::VAL_W-1:0] metric;
    logic [zhwr_pkg::METRIC_INPUTS-1:0][zhwr_pkg::REL_W-1:0] lane_rel;
    zhwr_pkg::t_merge           merged;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign metric[0] = r_item.sleep_metric;
    assign metric[1] = r_item.emotion_metric;
    assign metric[2] = r_item.work_metric;
    assign metric[3] = r_item.energy_metric;
    assign metric[4] = r_item.comfort_metric;

    // One lane per metric; weights follow the newly confirmed zone
    for (genvar g = 0; g < zhwr_pkg::METRIC_INPUTS; g++) begin : g_lane
        zhwr_lane u_lane (
            .i_clk    (i_clk),
            .i_weight (zhwr_pkg::WEIGHTS[r_zone][g]),
            .i_value  (metric[g]),
            .o_rel    (lane_rel[g])
        );
    end

    zhwr_merge u_merge (
        .i_rels    (lane_rel),
        .i_min_rel (r_min_rel),
        .o_merge   (merged)
    );

    // Evaluate one item: manual advance, zone hysteresis or dwell counting
    always_comb begin
        zhwr_pkg::t_zone nz;
        logic [2:0]      cc_inc;
        logic [7:0]      dwell_inc;
        zhwr_pkg::t_face pos_inc;
        nz        = zhwr_pkg::zone_of(r_item.score);
        cc_inc    = r_cc + 3'd1;
        dwell_inc = (r_dwell < zhwr_pkg::DWELL_MAX) ? (r_dwell + 8'd1) : r_dwell;
        pos_inc   = ((r_pos + 3'd1) >= r_len) ? 3'd0 : (r_pos + 3'd1);
        n_zone    = r_zone;
        n_pend    = r_pend;
        n_cc      = r_cc;
        n_dwell   = r_dwell;
        n_pos     = r_pos;
        n_rebuild = 1'b0;
        if (r_item.func == zhwr_pkg::FUNC_ADVANCE) begin
            if (r_len != 3'd0) begin
                n_pos   = pos_inc;
                n_dwell = '0;
            end
        end else if (nz != r_zone) begin
            if (nz == r_pend) begin
                n_cc = cc_inc;
                if (cc_inc >= r_confirm) begin
                    // confirmed: switch zone and rebuild the rotation
                    n_zone    = nz;
                    n_cc      = '0;
                    n_rebuild = 1'b1;
                end
            end else begin
                n_pend = nz;
                n_cc   = 3'd1;
            end
        end else begin
            n_pend  = r_zone;
            n_cc    = '0;
            n_dwell = dwell_inc;
            if (dwell_inc >= r_dwell_len && r_len != 3'd0) begin
                n_pos   = pos_inc;
                n_dwell = '0;
            end
        end
    end

    // One compare-exchange of the sort, pair chosen by the step count
    always_comb begin
        n_face = r_face;
        n_srel = r_srel;
        for (int p = 0; p < zhwr_pkg::SORT_STEPS; p++) begin
            if (r_step == zhwr_pkg::STEP_W'(p)
                    && 3'(zhwr_pkg::SORT_J[p]) < r_len
                    && r_srel[zhwr_pkg::SORT_J[p]] > r_srel[zhwr_pkg::SORT_I[p]]) begin
                n_face[zhwr_pkg::SORT_I[p]] = r_face[zhwr_pkg::SORT_J[p]];
                n_face[zhwr_pkg::SORT_J[p]] = r_face[zhwr_pkg::SORT_I[p]];
                n_srel[zhwr_pkg::SORT_I[p]] = r_srel[zhwr_pkg::SORT_J[p]];
                n_srel[zhwr_pkg::SORT_J[p]] = r_srel[zhwr_pkg::SORT_I[p]];
            end
        end
    end

    always_comb begin
        n_out.face_now          = (r_len == 3'd0) ? 3'd0 : r_face[r_pos];
        n_out.zone_now          = r_zone;
        n_out.faces_in_rotation = r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_dwell_len   <= zhwr_pkg::RST_DWELL_LEN;
            r_min_rel     <= zhwr_pkg::RST_REL_FLOOR;
            r_confirm     <= zhwr_pkg::RST_CONFIRM_COUNT;
            r_zone        <= '0;
            r_pend        <= '0;
            r_cc          <= '0;
            r_dwell       <= '0;
            r_len         <= '0;
            r_pos         <= '0;
            r_step        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    zhwr_pkg::CFG_DWELL_LEN:     r_dwell_len <= i_cfg_data;
                    zhwr_pkg::CFG_REL_FLOOR:     r_min_rel   <= i_cfg_data;
                    zhwr_pkg::CFG_CONFIRM_COUNT: r_confirm   <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            // result register: loaded from S_OUT, cleared once taken downstream
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_zone  <= n_zone;
                    r_pend  <= n_pend;
                    r_cc    <= n_cc;
                    r_dwell <= n_dwell;
                    r_pos   <= n_pos;
                    r_state <= n_rebuild ? S_LANE1 : S_OUT;
                end
                S_LANE1: r_state <= S_LANE2;
                S_LANE2: r_state <= S_MERGE;
                S_MERGE: begin
                    r_face  <= merged.faces;
                    r_srel  <= merged.rels;
                    r_len   <= merged.count;
                    r_pos   <= '0;
                    r_dwell <= '0;
                    r_step  <= '0;
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    r_face <= n_face;
                    r_srel <= n_srel;
                    r_step <= r_step + 1'b1;
                    if (r_step == zhwr_pkg::STEP_W'(zhwr_pkg::SORT_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait here while the previous result is still unclaimed
                    if (!r_out_valid || i_out_ready) begin
                        r_out_data  <= n_out;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/zhwr_lane.sv
// zhwr_lane: relevance of one metric, weight * |value - 50| / 50, in two
// registered stages (multiply, then reciprocal divide). Uses zhwr_pkg.
module zhwr_lane (
    input  logic                         i_clk,
    input  logic [zhwr_pkg::WGT_W-1:0]   i_weight,
    input  logic [zhwr_pkg::VAL_W-1:0]   i_value,
    output zhwr_pkg::t_rel               o_rel
);

    logic [zhwr_pkg::VAL_W-1:0]   dev;
    logic [zhwr_pkg::PROD_W-1:0]  r_prod;
    logic [zhwr_pkg::SCALE_W-1:0] scaled;
    zhwr_pkg::t_rel               r_rel;

    assign dev = (i_value > zhwr_pkg::NEUTRAL) ? (i_value - zhwr_pkg::NEUTRAL)
                                                : (zhwr_pkg::NEUTRAL - i_value);

    assign scaled = zhwr_pkg::SCALE_W'(r_prod) * zhwr_pkg::SCALE_W'(zhwr_pkg::RECIP_50);

    always_ff @(posedge i_clk) begin
        r_prod <= zhwr_pkg::PROD_W'(dev) * zhwr_pkg::PROD_W'(i_weight);
        r_rel  <= scaled[zhwr_pkg::RECIP_SHIFT +: zhwr_pkg::REL_W];
    end

    assign o_rel = r_rel;

endmodule

### hdl/zhwr_merge.sv
// zhwr_merge: gathers the lanes whose relevance clears the minimum into a
// packed list in metric order, with the count. Uses zhwr_pkg.
module zhwr_merge (
    input  logic [zhwr_pkg::METRIC_INPUTS-1:0][zhwr_pkg::REL_W-1:0] i_rels,
    input  zhwr_pkg::t_rel                                          i_min_rel,
    output zhwr_pkg::t_merge                                        o_merge
);

    always_comb begin
        zhwr_pkg::t_merge          res;
        logic [zhwr_pkg::SLOT_W-1:0] k;
        res = '0;
        k   = '0;
        for (int i = 0; i < zhwr_pkg::METRIC_INPUTS; i++) begin
            if (i < zhwr_pkg::NUM_METRICS && i_rels[i] >= i_min_rel) begin
                res.faces[k] = 3'(i);
                res.rels[k]  = i_rels[i];
                k            = k + 1'b1;
            end
        end
        res.count = 3'(k);
        o_merge   = res;
    end

endmodule

### hdl/zhwr_checker.sv
// zhwr_checker: port-level assertions for the rotation unit, bound to the
// top level. Uses zhwr_pkg types.
module zhwr_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           o_out_valid,
    input  logic           i_out_ready,
    input  zhwr_pkg::t_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // list never longer than the metric count
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.faces_in_rotation <= 3'(zhwr_pkg::METRIC_INPUTS))
        else $error("rotation length out of range");

    // empty rotation shows face 0
    a_empty_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.faces_in_rotation == 3'd0 |-> o_out_data.face_now == 3'd0)
        else $error("face shown with an empty rotation");

    // a shown face is a real metric index
    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.face_now < 3'(zhwr_pkg::METRIC_INPUTS))
        else $error("face index out of range");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind zone_hysteresis_weighted_rotation_unit zhwr_checker u_zhwr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
